[design/sab_pkg.sv]
// sab_pkg: constants, controller states and the control/status structs
// shared by the suffix automaton builder modules; no dependencies
package sab_pkg;

  localparam int MAX_TEXT  = 4096;
  localparam int ALPHABET  = 26;
  localparam int NSTATES   = 2 * MAX_TEXT;
  localparam int IDX_W     = 13;
  localparam int SYM_W     = 5;
  localparam int LEN_W     = 13;
  localparam int POS_W     = 12;
  localparam int CNT_W     = 14;
  localparam int ROW_W     = IDX_W + SYM_W;
  localparam int ROW_DEPTH = NSTATES * (2 ** SYM_W);

  typedef enum logic [3:0] {
    ST_RINIT,
    ST_IDLE,
    ST_RDLEN,
    ST_SETLEN,
    ST_CLR,
    ST_WRD,
    ST_WCHK,
    ST_LQ,
    ST_LP,
    ST_CMP,
    ST_CLONE,
    ST_CPY,
    ST_RRD,
    ST_RCHK,
    ST_LINKQ,
    ST_FIN
  } sab_state_e;

  typedef struct packed {
    sab_state_e op;
    logic       accept;
  } sab_cmd_t;

  typedef struct packed {
    logic drop;
    logic k_last;
    logic k_end;
    logic hit;
    logic at_root;
    logic solid;
    logic match;
  } sab_stat_t;

endpackage

[design/sab_ram.sv]
// sab_ram: generic single write port, single read port ram with registered read
// no dependencies
module sab_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/sab_ctrl.sv]
// sab_ctrl: controller state machine sequencing root clear, walk, clone and copy
// depends on sab_pkg
module sab_ctrl import sab_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  sab_stat_t stat_i,
  output sab_cmd_t  cmd_o,
  output logic      busy_o
);

  sab_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RINIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RINIT:  if (stat_i.k_last) state_d = ST_IDLE;
      ST_IDLE:   if (start_i && !stat_i.drop) state_d = ST_RDLEN;
      ST_RDLEN:  state_d = ST_SETLEN;
      ST_SETLEN: state_d = ST_CLR;
      ST_CLR:    if (stat_i.k_last) state_d = ST_WRD;
      ST_WRD:    state_d = ST_WCHK;
      ST_WCHK: begin
        if (stat_i.hit) state_d = ST_LQ;
        else if (stat_i.at_root) state_d = ST_FIN;
        else state_d = ST_WRD;
      end
      ST_LQ:     state_d = ST_LP;
      ST_LP:     state_d = ST_CMP;
      ST_CMP:    state_d = stat_i.solid ? ST_FIN : ST_CLONE;
      ST_CLONE:  state_d = ST_CPY;
      ST_CPY:    if (stat_i.k_end) state_d = ST_RRD;
      ST_RRD:    state_d = ST_RCHK;
      ST_RCHK: begin
        if (!stat_i.match || stat_i.at_root) state_d = ST_LINKQ;
        else state_d = ST_RRD;
      end
      ST_LINKQ:  state_d = ST_FIN;
      ST_FIN:    state_d = ST_IDLE;
      default:   state_d = ST_RINIT;
    endcase
  end

  always_comb begin
    cmd_o.op     = state_q;
    cmd_o.accept = (state_q == ST_IDLE) && start_i;
    busy_o       = (state_q != ST_IDLE);
  end

endmodule

[design/sab_dp.sv]
// sab_dp: datapath with counters, working registers, result registers and the
// length, link, end position and transition rams; depends on sab_pkg, sab_ram
module sab_dp import sab_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sab_cmd_t         cmd_i,
  input  logic [SYM_W-1:0] symbol_i,
  output sab_stat_t        stat_o,
  output logic             done_o,
  output logic [IDX_W-1:0] new_state_o,
  output logic [IDX_W-1:0] link_of_new_o,
  output logic             cloned_o,
  output logic [IDX_W-1:0] clone_index_o,
  output logic [IDX_W-1:0] state_count_o,
  output logic [IDX_W-1:0] text_length_o,
  output logic             full_res_o
);

  logic [IDX_W-1:0] last_q, cur_q, p_q, q_q, clone_q, link_q;
  logic [CNT_W-1:0] su_q;
  logic [IDX_W-1:0] sa_q;
  logic [SYM_W-1:0] sym_q, k_q;
  logic [LEN_W-1:0] lenq_q, lenp_q;
  logic             cloned_q;
  logic             done_q, full_q, rcl_q;
  logic [IDX_W-1:0] r_new_q, r_link_q, r_clone_q, r_cnt_q, r_len_q;

  logic             t_we, l_we, k_we, e_we;
  logic [ROW_W-1:0] t_wa, t_ra;
  logic [IDX_W-1:0] t_wd, t_rd;
  logic [IDX_W-1:0] l_wa, l_ra, k_wa, k_ra, e_wa, e_ra;
  logic [LEN_W-1:0] l_wd, l_rd;
  logic [IDX_W-1:0] k_wd, k_rd;
  logic [POS_W-1:0] e_wd, e_rd;
  logic             is_full;
  logic [SYM_W-1:0] k_m1;

  assign is_full = (sa_q == IDX_W'(MAX_TEXT));
  assign k_m1    = k_q - SYM_W'(1);

  always_comb begin
    stat_o.drop    = is_full || (symbol_i >= SYM_W'(ALPHABET))
                     || (su_q > CNT_W'(NSTATES - 2));
    stat_o.k_last  = (k_q == SYM_W'(ALPHABET - 1));
    stat_o.k_end   = (k_q == SYM_W'(ALPHABET));
    stat_o.hit     = (t_rd != '0);
    stat_o.at_root = (p_q == '0);
    stat_o.solid   = (lenq_q == l_rd + LEN_W'(1));
    stat_o.match   = (t_rd == q_q);
  end

  always_comb begin
    t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = {p_q, sym_q};
    l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = last_q;
    k_we = 1'b0; k_wa = '0; k_wd = '0; k_ra = p_q;
    e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = q_q;
    case (cmd_i.op)
      ST_RINIT: begin
        t_we = 1'b1; t_wa = {IDX_W'(0), k_q};
        l_we = 1'b1; l_wa = '0;
      end
      ST_SETLEN: begin
        l_we = 1'b1; l_wa = cur_q; l_wd = l_rd + LEN_W'(1);
        e_we = 1'b1; e_wa = cur_q; e_wd = sa_q[POS_W-1:0];
      end
      ST_CLR: begin
        t_we = 1'b1; t_wa = {cur_q, k_q};
      end
      ST_WCHK: begin
        t_we = !stat_o.hit; t_wa = {p_q, sym_q}; t_wd = cur_q;
      end
      ST_LQ:  l_ra = q_q;
      ST_LP:  l_ra = p_q;
      ST_CMP: l_ra = p_q;
      ST_CLONE: begin
        l_we = 1'b1; l_wa = su_q[IDX_W-1:0]; l_wd = lenp_q + LEN_W'(1);
        k_ra = q_q;
      end
      ST_CPY: begin
        k_ra = q_q;
        t_ra = {q_q, k_q};
        t_we = (k_q != '0); t_wa = {clone_q, k_m1}; t_wd = t_rd;
        k_we = (k_q == '0); k_wa = clone_q; k_wd = k_rd;
        e_we = (k_q == '0); e_wa = clone_q; e_wd = e_rd;
      end
      ST_RCHK: begin
        t_we = stat_o.match; t_wa = {p_q, sym_q}; t_wd = clone_q;
      end
      ST_LINKQ: begin
        k_we = 1'b1; k_wa = q_q; k_wd = clone_q;
      end
      ST_FIN: begin
        k_we = 1'b1; k_wa = cur_q; k_wd = link_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      su_q     <= CNT_W'(1);
      sa_q     <= '0;
      k_q      <= '0;
      done_q   <= 1'b0;
      cloned_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (cmd_i.op)
        ST_RINIT: k_q <= k_q + SYM_W'(1);
        ST_IDLE: begin
          if (cmd_i.accept) begin
            sym_q    <= symbol_i;
            cloned_q <= 1'b0;
            link_q   <= '0;
            if (stat_o.drop) begin
              done_q    <= 1'b1;
              full_q    <= is_full;
              r_new_q   <= '0;
              r_link_q  <= '0;
              rcl_q     <= 1'b0;
              r_clone_q <= '0;
              r_cnt_q   <= su_q[IDX_W-1:0];
              r_len_q   <= sa_q;
            end else begin
              cur_q <= su_q[IDX_W-1:0];
              su_q  <= su_q + CNT_W'(1);
              p_q   <= last_q;
            end
          end
        end
        ST_SETLEN: k_q <= '0;
        ST_CLR:    k_q <= k_q + SYM_W'(1);
        ST_WCHK: begin
          if (stat_o.hit) q_q <= t_rd;
          else p_q <= k_rd;
        end
        ST_LP: lenq_q <= l_rd;
        ST_CMP: begin
          lenp_q <= l_rd;
          if (stat_o.solid) link_q <= q_q;
        end
        ST_CLONE: begin
          clone_q  <= su_q[IDX_W-1:0];
          link_q   <= su_q[IDX_W-1:0];
          su_q     <= su_q + CNT_W'(1);
          cloned_q <= 1'b1;
          k_q      <= '0;
        end
        ST_CPY: k_q <= k_q + SYM_W'(1);
        ST_RCHK: if (stat_o.match) p_q <= k_rd;
        ST_FIN: begin
          last_q    <= cur_q;
          sa_q      <= sa_q + IDX_W'(1);
          done_q    <= 1'b1;
          full_q    <= 1'b0;
          r_new_q   <= cur_q;
          r_link_q  <= link_q;
          rcl_q     <= cloned_q;
          r_clone_q <= cloned_q ? clone_q : '0;
          r_cnt_q   <= su_q[IDX_W-1:0];
          r_len_q   <= sa_q + IDX_W'(1);
        end
        default: ;
      endcase
    end
  end

  sab_ram #(.Width(IDX_W), .Depth(ROW_DEPTH)) u_trans (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(t_wd), .raddr_i(t_ra), .rdata_o(t_rd)
  );
  sab_ram #(.Width(LEN_W), .Depth(NSTATES)) u_len (
    .clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd), .raddr_i(l_ra), .rdata_o(l_rd)
  );
  sab_ram #(.Width(IDX_W), .Depth(NSTATES)) u_link (
    .clk_i, .we_i(k_we), .waddr_i(k_wa), .wdata_i(k_wd), .raddr_i(k_ra), .rdata_o(k_rd)
  );
  sab_ram #(.Width(POS_W), .Depth(NSTATES)) u_endpos (
    .clk_i, .we_i(e_we), .waddr_i(e_wa), .wdata_i(e_wd), .raddr_i(e_ra), .rdata_o(e_rd)
  );

  assign done_o        = done_q;
  assign new_state_o   = r_new_q;
  assign link_of_new_o = r_link_q;
  assign cloned_o      = rcl_q;
  assign clone_index_o = r_clone_q;
  assign state_count_o = r_cnt_q;
  assign text_length_o = r_len_q;
  assign full_res_o    = full_q;

endmodule

[design/suffix_automaton_builder_top.sv]
// suffix_automaton_builder_top: online suffix automaton builder, one symbol per command
// depends on sab_pkg, sab_ctrl, sab_dp
//
//   channel  handshake            payload
//   input    start_i & !busy_o    symbol_i
//   result   done_o (one cycle)   new_state_o link_of_new_o cloned_o clone_index_o
//                                 state_count_o text_length_o full_res_o
//
// a symbol reads the last state's length, clears the new state's row, then walks the
// suffix links; when the walk finds a transition it compares the lengths, and on a
// clone it copies the row and walks the redirect steps; all from the one write, one
// read port rams. dropped symbols report in the cycle after the transfer.
// after reset busy_o stays high while the root row is cleared.
// results cannot be stalled; done_o is a single cycle strobe.
module suffix_automaton_builder_top import sab_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [SYM_W-1:0] symbol_i,
  output logic             done_o,
  output logic [IDX_W-1:0] new_state_o,
  output logic [IDX_W-1:0] link_of_new_o,
  output logic             cloned_o,
  output logic [IDX_W-1:0] clone_index_o,
  output logic [IDX_W-1:0] state_count_o,
  output logic [IDX_W-1:0] text_length_o,
  output logic             full_res_o
);

  sab_cmd_t  cmd;
  sab_stat_t stat;

  sab_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .stat_i(stat), .cmd_o(cmd), .busy_o
  );

  sab_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .symbol_i, .stat_o(stat), .done_o,
    .new_state_o, .link_of_new_o, .cloned_o, .clone_index_o,
    .state_count_o, .text_length_o, .full_res_o
  );

endmodule

[bench/tb.sv]
// tb: self-checking bench for suffix_automaton_builder_top, predicts each result
// with an in-bench automaton model; depends on sab_pkg and the design sources
module tb import sab_pkg::*; ();

  typedef struct packed {
    logic [IDX_W-1:0] new_state;
    logic [IDX_W-1:0] link_of_new;
    logic             cloned;
    logic [IDX_W-1:0] clone_index;
    logic [IDX_W-1:0] state_count;
    logic [IDX_W-1:0] text_length;
    logic             full_res;
  } sa_result_t;

  localparam int WATCHDOG_LIMIT = 60000;

  logic             clk_i, rst_ni, start_i, busy_o, done_o, cloned_o, full_res_o;
  logic [SYM_W-1:0] symbol_i;
  logic [IDX_W-1:0] new_state_o, link_of_new_o, clone_index_o, state_count_o;
  logic [IDX_W-1:0] text_length_o;

  suffix_automaton_builder_top i_dut (.*);

  logic [LEN_W-1:0] sa_len [NSTATES];
  logic [IDX_W-1:0] sa_link [NSTATES];
  logic [IDX_W-1:0] sa_trans [NSTATES][ALPHABET];
  int unsigned      sa_last, sa_used, sa_added;

  sa_result_t expected_q [$];
  bit         failed;
  int         idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic sa_result_t extend_automaton(logic [SYM_W-1:0] sym);
    sa_result_t r;
    int unsigned cur, lnk, cl, p, q;
    bit full, found;
    full = (sa_added >= MAX_TEXT);
    cur = 0; lnk = 0; cl = 0; found = 0;
    r = '0;
    if (!full && sym < ALPHABET && sa_used + 2 <= NSTATES) begin
      cur = sa_used++;
      sa_len[cur] = LEN_W'(sa_len[sa_last] + 1);
      for (int a = 0; a < ALPHABET; a++) sa_trans[cur][a] = '0;
      p = sa_last;
      forever begin
        if (sa_trans[p][sym] != 0) begin
          found = 1;
          break;
        end
        sa_trans[p][sym] = IDX_W'(cur);
        if (p == 0) break;
        p = sa_link[p];
      end
      if (found) begin
        q = sa_trans[p][sym];
        if (sa_len[q] == sa_len[p] + 1) begin
          lnk = q;
        end else begin
          cl = sa_used++;
          r.cloned = 1'b1;
          sa_len[cl] = LEN_W'(sa_len[p] + 1);
          sa_link[cl] = sa_link[q];
          for (int a = 0; a < ALPHABET; a++) sa_trans[cl][a] = sa_trans[q][a];
          forever begin
            if (sa_trans[p][sym] != q) break;
            sa_trans[p][sym] = IDX_W'(cl);
            if (p == 0) break;
            p = sa_link[p];
          end
          sa_link[q] = IDX_W'(cl);
          lnk = cl;
        end
      end
      sa_link[cur] = IDX_W'(lnk);
      sa_last = cur;
      sa_added++;
    end
    r.new_state   = IDX_W'(cur);
    r.link_of_new = IDX_W'(lnk);
    r.clone_index = IDX_W'(cl);
    r.state_count = IDX_W'(sa_used);
    r.text_length = IDX_W'(sa_added);
    r.full_res    = full;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_symbol(logic [SYM_W-1:0] sym, int gap);
    @(negedge clk_i);
    start_i  <= 1'b1;
    symbol_i <= sym;
    do @(posedge clk_i); while (busy_o);
    expected_q.push_back(extend_automaton(sym));
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp, act);
      failed = 1;
    end
  endtask

  always @(posedge clk_i) begin
    sa_result_t e;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result transfer, new_state actual %0d", $time, new_state_o);
        failed = 1;
      end else begin
        e = expected_q.pop_front();
        check_field("new_state", e.new_state, new_state_o);
        check_field("link_of_new", e.link_of_new, link_of_new_o);
        check_field("cloned", e.cloned, cloned_o);
        check_field("clone_index", e.clone_index, clone_index_o);
        check_field("state_count", e.state_count, state_count_o);
        check_field("text_length", e.text_length, text_length_o);
        check_field("full_res", e.full_res, full_res_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start_i && !busy_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    logic [SYM_W-1:0] seq [] = '{0, 25, 0, 25, 0, 26, 31, 1, 0, 0, 0, 1, 0, 0, 1, 25, 16, 15};
    foreach (seq[i]) send_symbol(seq[i], pick_gap());
  endtask

  task automatic test_random_text();
    int span;
    for (int blk = 0; blk < 19; blk++) begin
      case ($urandom_range(0, 3))
        0: span = 1;
        1: span = 2;
        2: span = 3;
        default: span = ALPHABET - 1;
      endcase
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_symbol(SYM_W'($urandom_range(ALPHABET, 31)), pick_gap());
        else if (blk % 4 == 3) send_symbol(SYM_W'($urandom_range(0, 31)), pick_gap());
        else send_symbol(SYM_W'($urandom_range(0, span)), pick_gap());
      end
    end
  endtask

  initial begin
    int guard;
    rst_ni = 1'b0; start_i = 1'b0; symbol_i = '0;
    failed = 0;
    for (int s = 0; s < NSTATES; s++) begin
      sa_len[s] = '0;
      sa_link[s] = '0;
      for (int a = 0; a < ALPHABET; a++) sa_trans[s][a] = '0;
    end
    sa_last = 0; sa_used = 1; sa_added = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_text();
    @(negedge clk_i);
    start_i <= 1'b0;
    guard = 0;
    while (expected_q.size() != 0 && guard < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (100) @(posedge clk_i);
    if (!failed && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
